// File: rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and helpers of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QBITS     = 32;
  localparam int LOW_BITS  = QBITS - FRAC_BITS;
  localparam int MMAG_BITS = 64 - FRAC_BITS;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_CMP = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] fix_real;
    logic [31:0] fix_imag;
    logic        equal;
    logic        div_zero;
    logic        saturated;
    logic        neg_real;
    logic        neg_imag;
  } side_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clamp_t;

  function automatic clamp_t clamp_mag(input logic neg, input logic big,
                                       input logic [31:0] mag);
    clamp_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (big || mag[31]) begin
        r.val = 32'h7FFF_FFFF;
        r.sat = 1'b1;
      end else begin
        r.val = mag;
      end
    end else begin
      if (big || (mag[31] && (|mag[30:0]))) begin
        r.val = 32'h8000_0000;
        r.sat = 1'b1;
      end else begin
        r.val = 32'(~mag + 32'd1);
      end
    end
    return r;
  endfunction

  function automatic clamp_t clamp_sum(input logic [32:0] s);
    clamp_t r;
    r.sat = s[32] != s[31];
    if (r.sat) begin
      r.val = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r.val = s[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Input register, product stage, sum stage and magnitude stage. Finishes
// add, subtract, multiply and compare; prepares numerators for division.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0]          kind,
  input  logic signed [31:0]  a_real,
  input  logic signed [31:0]  a_imag,
  input  logic signed [31:0]  b_real,
  input  logic signed [31:0]  b_imag,
  output logic                f_valid,
  output cau_pkg::side_t      f_side,
  output logic [63:0]         f_num_real,
  output logic [63:0]         f_num_imag,
  output logic [63:0]         f_den
);

  logic               s1_valid;
  logic [2:0]         s1_kind;
  logic signed [31:0] s1_ar, s1_ai, s1_br, s1_bi;

  logic               s2_valid;
  cau_pkg::side_t     s2_side;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir, p_bb1, p_bb2;

  logic               s3_valid;
  cau_pkg::side_t     s3_side;
  logic signed [64:0] s3_re, s3_im;
  logic [63:0]        s3_den;

  cau_pkg::side_t     s2_side_next;
  cau_pkg::clamp_t    c_r, c_i;
  logic               is_sub;
  logic [32:0]        sum_r, sum_i;

  logic signed [64:0] re_next, im_next;
  logic [63:0]        den_next;

  cau_pkg::side_t     f_side_next;
  logic [64:0]        abs_re, abs_im;
  logic [cau_pkg::MMAG_BITS-1:0] m_re, m_im;
  cau_pkg::clamp_t    m_cr, m_ci;

  always_comb begin
    is_sub = s1_kind == cau_pkg::KIND_SUB;
    sum_r = is_sub ? 33'(s1_ar) - 33'(s1_br) : 33'(s1_ar) + 33'(s1_br);
    sum_i = is_sub ? 33'(s1_ai) - 33'(s1_bi) : 33'(s1_ai) + 33'(s1_bi);
    c_r = cau_pkg::clamp_sum(sum_r);
    c_i = cau_pkg::clamp_sum(sum_i);
    s2_side_next = '0;
    s2_side_next.kind = s1_kind;
    case (s1_kind)
      cau_pkg::KIND_ADD, cau_pkg::KIND_SUB: begin
        s2_side_next.fix_real  = c_r.val;
        s2_side_next.fix_imag  = c_i.val;
        s2_side_next.saturated = c_r.sat | c_i.sat;
      end
      cau_pkg::KIND_CMP: begin
        s2_side_next.equal = (s1_ar == s1_br) && (s1_ai == s1_bi);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (s2_side.kind == cau_pkg::KIND_MUL) begin
      re_next = 65'(p_rr) - 65'(p_ii);
      im_next = 65'(p_ri) + 65'(p_ir);
    end else begin
      re_next = 65'(p_rr) + 65'(p_ii);
      im_next = 65'(p_ir) - 65'(p_ri);
    end
    den_next = $unsigned(p_bb1) + $unsigned(p_bb2);
  end

  always_comb begin
    abs_re = s3_re[64] ? 65'(-s3_re) : 65'(s3_re);
    abs_im = s3_im[64] ? 65'(-s3_im) : 65'(s3_im);
    m_re = abs_re[63:cau_pkg::FRAC_BITS];
    m_im = abs_im[63:cau_pkg::FRAC_BITS];
    m_cr = cau_pkg::clamp_mag(s3_re[64], |m_re[cau_pkg::MMAG_BITS-1:32], m_re[31:0]);
    m_ci = cau_pkg::clamp_mag(s3_im[64], |m_im[cau_pkg::MMAG_BITS-1:32], m_im[31:0]);
    f_side_next = s3_side;
    f_side_next.neg_real = s3_re[64];
    f_side_next.neg_imag = s3_im[64];
    case (s3_side.kind)
      cau_pkg::KIND_MUL: begin
        f_side_next.fix_real  = m_cr.val;
        f_side_next.fix_imag  = m_ci.val;
        f_side_next.saturated = m_cr.sat | m_ci.sat;
      end
      cau_pkg::KIND_DIV: begin
        f_side_next.div_zero = s3_den == 64'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      f_valid  <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      f_valid  <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind    <= kind;
      s1_ar      <= a_real;
      s1_ai      <= a_imag;
      s1_br      <= b_real;
      s1_bi      <= b_imag;
      s2_side    <= s2_side_next;
      p_rr       <= s1_ar * s1_br;
      p_ii       <= s1_ai * s1_bi;
      p_ri       <= s1_ar * s1_bi;
      p_ir       <= s1_ai * s1_br;
      p_bb1      <= s1_br * s1_br;
      p_bb2      <= s1_bi * s1_bi;
      s3_side    <= s2_side;
      s3_re      <= re_next;
      s3_im      <= im_next;
      s3_den     <= den_next;
      f_side     <= f_side_next;
      f_num_real <= abs_re[63:0];
      f_num_imag <= abs_im[63:0];
      f_den      <= s3_den;
    end
  end

endmodule

// File: rtl/cau_divider.sv
// ----------------------------------------------------------------------------
// cau_divider
// Pipelined restoring divider, one quotient bit per stage, two lanes
// (real and imaginary) sharing one denominator.
// ----------------------------------------------------------------------------
module cau_divider (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   d_valid,
  input  cau_pkg::side_t         d_side,
  input  logic [63:0]            num_real,
  input  logic [63:0]            num_imag,
  input  logic [63:0]            den,
  output logic                   q_valid,
  output cau_pkg::side_t         q_side,
  output logic [cau_pkg::QBITS-1:0] quo_real,
  output logic [cau_pkg::QBITS-1:0] quo_imag,
  output logic                   ovf_real,
  output logic                   ovf_imag
);

  localparam int NST = cau_pkg::QBITS;
  localparam int LB  = cau_pkg::LOW_BITS;

  logic [NST:0]               vld;
  cau_pkg::side_t             sd   [NST+1];
  logic [63:0]                dv   [NST+1];
  logic [63:0]                rem  [2][NST+1];
  logic [LB-1:0]              nb   [2][NST+1];
  logic [cau_pkg::QBITS-1:0]  quo  [2][NST+1];
  logic                       ovf  [2][NST+1];

  logic [63:0]                num  [2];
  logic [63:0]                init [2];
  logic [64:0]                tr   [2][NST];
  logic                       ge   [2][NST];

  always_comb begin
    num[0] = num_real;
    num[1] = num_imag;
    for (int l = 0; l < 2; l++) begin
      init[l] = num[l] >> LB;
      for (int j = 0; j < NST; j++) begin
        tr[l][j] = {rem[l][j], nb[l][j][LB-1]};
        ge[l][j] = tr[l][j] >= {1'b0, dv[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:0], d_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= d_side;
      dv[0] <= den;
      for (int l = 0; l < 2; l++) begin
        rem[l][0] <= init[l];
        ovf[l][0] <= init[l] >= den;
        nb[l][0]  <= num[l][LB-1:0];
        quo[l][0] <= '0;
      end
      for (int j = 0; j < NST; j++) begin
        sd[j+1] <= sd[j];
        dv[j+1] <= dv[j];
        for (int l = 0; l < 2; l++) begin
          rem[l][j+1] <= ge[l][j] ? 64'(tr[l][j] - {1'b0, dv[j]}) : tr[l][j][63:0];
          ovf[l][j+1] <= ovf[l][j];
          nb[l][j+1]  <= nb[l][j] << 1;
          quo[l][j+1] <= {quo[l][j][cau_pkg::QBITS-2:0], ge[l][j]};
        end
      end
    end
  end

  assign q_valid  = vld[NST];
  assign q_side   = sd[NST];
  assign quo_real = quo[0][NST];
  assign quo_imag = quo[1][NST];
  assign ovf_real = ovf[0][NST];
  assign ovf_imag = ovf[1][NST];

endmodule

// File: rtl/complex_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Complex add, subtract, multiply, divide and compare on signed Q16.16.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle while the output is not stalled.
// Every operation passes through the same stages from input to output register:
// four front stages (input, products, sums, magnitudes), a 33-stage
// pipelined divider producing one quotient bit per stage, and the output
// register. Results leave in input order; a stall on the output freezes the
// whole pipeline.
module complex_arithmetic_unit_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         kind,
  input  logic signed [31:0] a_real,
  input  logic signed [31:0] a_imag,
  input  logic signed [31:0] b_real,
  input  logic signed [31:0] b_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] res_real,
  output logic signed [31:0] res_imag,
  output logic               equal,
  output logic               div_zero,
  output logic               saturated
);

  logic                          en;
  logic                          f_valid;
  cau_pkg::side_t                f_side;
  logic [63:0]                   f_num_real, f_num_imag, f_den;
  logic                          q_valid;
  cau_pkg::side_t                q_side;
  logic [cau_pkg::QBITS-1:0]     quo_real, quo_imag;
  logic                          ovf_real, ovf_imag;
  cau_pkg::clamp_t               c_r, c_i;
  logic [31:0]                   res_real_next, res_imag_next;
  logic                          sat_next;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  cau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .kind       (kind),
    .a_real     (a_real),
    .a_imag     (a_imag),
    .b_real     (b_real),
    .b_imag     (b_imag),
    .f_valid    (f_valid),
    .f_side     (f_side),
    .f_num_real (f_num_real),
    .f_num_imag (f_num_imag),
    .f_den      (f_den)
  );

  cau_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .d_valid  (f_valid),
    .d_side   (f_side),
    .num_real (f_num_real),
    .num_imag (f_num_imag),
    .den      (f_den),
    .q_valid  (q_valid),
    .q_side   (q_side),
    .quo_real (quo_real),
    .quo_imag (quo_imag),
    .ovf_real (ovf_real),
    .ovf_imag (ovf_imag)
  );

  always_comb begin
    c_r = cau_pkg::clamp_mag(q_side.neg_real, ovf_real, quo_real);
    c_i = cau_pkg::clamp_mag(q_side.neg_imag, ovf_imag, quo_imag);
    if (q_side.kind == cau_pkg::KIND_DIV && !q_side.div_zero) begin
      res_real_next = c_r.val;
      res_imag_next = c_i.val;
      sat_next      = c_r.sat | c_i.sat;
    end else begin
      res_real_next = q_side.fix_real;
      res_imag_next = q_side.fix_imag;
      sat_next      = q_side.saturated;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_real  <= res_real_next;
      res_imag  <= res_imag_next;
      equal     <= q_side.equal;
      div_zero  <= q_side.div_zero;
      saturated <= sat_next;
    end
  end

endmodule

// File: rtl/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] res_real,
  input logic signed [31:0] res_imag,
  input logic               equal,
  input logic               div_zero,
  input logic               saturated
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_real) && $stable(res_imag))
    else $error("stalled transaction changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_cmp: assert property (@(posedge clk) disable iff (rst)
    out_valid && equal |-> res_real == 0 && res_imag == 0 && !saturated && !div_zero)
    else $error("compare transaction carries data");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> res_real == 0 && res_imag == 0 && !saturated)
    else $error("zero divisor transaction carries data");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .res_real  (res_real),
  .res_imag  (res_imag),
  .equal     (equal),
  .div_zero  (div_zero),
  .saturated (saturated)
);

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Applies a table of directed transactions and then random ones under changing
// valid and stall patterns. Every result is checked against an in-order queue
// of expected results, typed in the table or from a behavioral Q16.16 model.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic        dz;
    logic        sat;
  } cplx_res_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] ar, ai, br, bi;
    bit          typed;
    cplx_res_t   res;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] kind = 3'd0;
  logic signed [31:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] res_real, res_imag;
  logic equal, div_zero, saturated;

  cplx_res_t result_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  complex_arithmetic_unit_core dut (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] clamp32(input logic signed [97:0] v, inout logic sat);
    if (v > 98'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -98'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [97:0] shift_trunc(input logic signed [65:0] p);
    logic signed [97:0] w;
    w = 98'(p);
    return (w < 0) ? -((-w) >>> cau_pkg::FRAC_BITS) : (w >>> cau_pkg::FRAC_BITS);
  endfunction

  function automatic logic signed [97:0] scaled_quot(input logic signed [65:0] n,
                                                     input logic [65:0] d);
    logic [97:0] mag;
    logic [97:0] q;
    mag = (n < 0) ? 98'(-n) : 98'(n);
    q = (mag << cau_pkg::FRAC_BITS) / 98'(d);
    return (n < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic cplx_res_t complex_op(input logic [2:0] k, input logic [31:0] ar,
                                           input logic [31:0] ai, input logic [31:0] br,
                                           input logic [31:0] bi);
    logic signed [65:0] xr, xi, yr, yi, pr, pi;
    logic [65:0] den;
    logic signed [97:0] vr, vi;
    cplx_res_t r;
    xr = $signed(ar);
    xi = $signed(ai);
    yr = $signed(br);
    yi = $signed(bi);
    r = '{re: '0, im: '0, eq: 1'b0, dz: 1'b0, sat: 1'b0};
    case (k)
      cau_pkg::KIND_ADD, cau_pkg::KIND_SUB: begin
        vr = (k == cau_pkg::KIND_ADD) ? xr + yr : xr - yr;
        vi = (k == cau_pkg::KIND_ADD) ? xi + yi : xi - yi;
        r.re = clamp32(vr, r.sat);
        r.im = clamp32(vi, r.sat);
      end
      cau_pkg::KIND_MUL: begin
        pr = xr * yr - xi * yi;
        pi = xr * yi + xi * yr;
        r.re = clamp32(shift_trunc(pr), r.sat);
        r.im = clamp32(shift_trunc(pi), r.sat);
      end
      cau_pkg::KIND_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          pr = xr * yr + xi * yi;
          pi = xi * yr - xr * yi;
          r.re = clamp32(scaled_quot(pr, den), r.sat);
          r.im = clamp32(scaled_quot(pi, den), r.sat);
        end
      end
      cau_pkg::KIND_CMP: r.eq = (ar == br) && (ai == bi);
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t: %s got %h expected %h", $realtime, field, got, want);
  endtask

  always @(posedge clk) begin
    cplx_res_t w;
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction", $realtime);
      end else begin
        w = result_q.pop_front();
        if (res_real !== w.re) report_mismatch("res_real", res_real, w.re);
        if (res_imag !== w.im) report_mismatch("res_imag", res_imag, w.im);
        if (equal !== w.eq) report_mismatch("equal", 32'(equal), 32'(w.eq));
        if (div_zero !== w.dz) report_mismatch("div_zero", 32'(div_zero), 32'(w.dz));
        if (saturated !== w.sat) report_mismatch("saturated", 32'(saturated), 32'(w.sat));
      end
    end
  end

  always @(negedge clk) begin
    int hold_cnt;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic send(input vec_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= v.kind;
    a_real <= v.ar;
    a_imag <= v.ai;
    b_real <= v.br;
    b_imag <= v.bi;
    do @(posedge clk); while (in_stall);
    result_q.push_back(v.typed ? v.res : complex_op(v.kind, v.ar, v.ai, v.br, v.bi));
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  function automatic cplx_res_t typed_res(input logic [31:0] re, input logic [31:0] im,
                                          input logic eq, input logic dz, input logic sat);
    cplx_res_t r;
    r = '{re: re, im: im, eq: eq, dz: dz, sat: sat};
    return r;
  endfunction

  initial begin
    vec_t table_v[$];
    vec_t v;
    int n;
    table_v.push_back('{cau_pkg::KIND_ADD, 0, 0, 0, 0, 1, typed_res(0, 0, 0, 0, 0)});
    table_v.push_back('{cau_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 1, typed_res(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1)});
    table_v.push_back('{cau_pkg::KIND_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'hFFFF_FFFF,
                        1, typed_res(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1)});
    table_v.push_back('{cau_pkg::KIND_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000,
                        32'h0001_0000, 1, typed_res(32'h0002_0000, 0, 0, 0, 0)});
    table_v.push_back('{cau_pkg::KIND_MUL, 32'h0001_0000, 32'h0000_0000, 32'h1234_5678,
                        32'h8765_4321, 1, typed_res(32'h1234_5678, 32'h8765_4321, 0, 0, 0)});
    table_v.push_back('{cau_pkg::KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 0, '{default: '0}});
    table_v.push_back('{cau_pkg::KIND_MUL, 32'hFFFF_FFFF, 0, 1, 0, 0, '{default: '0}});
    table_v.push_back('{cau_pkg::KIND_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 0, '{default: '0}});
    table_v.push_back('{cau_pkg::KIND_DIV, 32'h1234_5678, 32'h7FFF_FFFF, 0, 0,
                        1, typed_res(0, 0, 0, 1, 0)});
    table_v.push_back('{cau_pkg::KIND_DIV, 32'h0006_0000, 32'h0002_0000, 32'h0001_0000, 0,
                        1, typed_res(32'h0006_0000, 32'h0002_0000, 0, 0, 0)});
    table_v.push_back('{cau_pkg::KIND_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0,
                        '{default: '0}});
    table_v.push_back('{cau_pkg::KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 0, '{default: '0}});
    table_v.push_back('{cau_pkg::KIND_DIV, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0003,
                        32'hFFFF_FFF9, 0, '{default: '0}});
    table_v.push_back('{cau_pkg::KIND_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 1, typed_res(0, 0, 1, 0, 0)});
    table_v.push_back('{cau_pkg::KIND_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFE, 1, typed_res(0, 0, 0, 0, 0)});
    table_v.push_back('{3'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        1, typed_res(0, 0, 0, 0, 0)});
    table_v.push_back('{3'd6, 1, 1, 1, 1, 1, typed_res(0, 0, 0, 0, 0)});
    table_v.push_back('{3'd7, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0,
                        1, typed_res(0, 0, 0, 0, 0)});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_v[i]) send(table_v[i]);

    for (n = 0; n < 1400; n++) begin
      if (n == 0) begin
        send_idle_pct = 13;
        recv_idle_pct = 72;
      end else if (n == 470) begin
        send_idle_pct = 72;
        recv_idle_pct = 13;
      end else if (n == 940) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == 300 || n == 1000) hold_req = 1'b1;
      if (n == 700 || n == 1200) begin
        in_valid <= 1'b0;
        wait (result_q.size() == 0);
        @(negedge clk);
      end
      v.typed = 1'b0;
      v.res = '{default: '0};
      v.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
      v.ar = rand_part();
      v.ai = rand_part();
      v.br = rand_part();
      v.bi = rand_part();
      if (v.kind == cau_pkg::KIND_DIV && $urandom_range(0, 19) == 0) begin
        v.br = 0;
        v.bi = 0;
      end
      if (v.kind == cau_pkg::KIND_CMP && $urandom_range(0, 2) == 0) begin
        v.br = v.ar;
        v.bi = ($urandom_range(0, 1) == 0) ? v.ai : v.ai ^ (32'd1 << $urandom_range(0, 31));
      end
      send(v);
    end
    in_valid <= 1'b0;
    recv_idle_pct = 0;

    wait (result_q.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("complex_arithmetic_unit_core: match");
    end else begin
      $display("complex_arithmetic_unit_core: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("complex_arithmetic_unit_core: mismatch");
    $finish;
  end

endmodule
